// File: design/lz77te_pkg.sv
package lz77te_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       eot;
  } item_t;

  localparam logic [7:0] PAD_CHAR = 8'h20;

  localparam logic REG_SEARCH_SIZE = 1'b0;
  localparam logic REG_LOOK_SIZE   = 1'b1;

endpackage

// File: design/lz77te_ram.sv
module lz77te_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/lz77te_front.sv
module lz77te_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_of_text,
  output logic                item_valid,
  input  logic                item_ready,
  output lz77te_pkg::item_t   item
);

  lz77te_pkg::item_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready   = (count != 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = q[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= '{data: data_byte, eot: end_of_text};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// File: design/lz77te_back.sv
module lz77te_back #(
  parameter int SEARCH_MAX = 256,
  parameter int LOOK_MAX   = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  lz77te_pkg::item_t                 item,
  input  logic [$clog2(SEARCH_MAX+1)-1:0]   s_eff,
  input  logic [$clog2(LOOK_MAX+1)-1:0]     l_eff,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [$clog2(SEARCH_MAX+1)-1:0]   match_offset,
  output logic [$clog2(LOOK_MAX+1)-1:0]     match_length,
  output logic [7:0]                        next_char,
  output logic                              char_is_pad,
  output logic                              last_token
);

  localparam int OFF_W = $clog2(SEARCH_MAX + 1);
  localparam int LEN_W = $clog2(LOOK_MAX + 1);
  localparam int LIW   = $clog2(LOOK_MAX);
  localparam int AW    = $clog2(SEARCH_MAX + LOOK_MAX);
  localparam int DEPTH = 2 ** AW;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_FIN, S_CONS} state_t;

  state_t         state;
  logic [7:0]     la [LOOK_MAX];
  logic [AW-1:0]  wp;
  logic [LEN_W-1:0] lf;
  logic [OFF_W-1:0] wf;
  logic           eotm;
  logic           active;
  logic [OFF_W-1:0] off;
  logic [LEN_W-1:0] k;
  logic [OFF_W-1:0] best_off;
  logic [LEN_W-1:0] best_len;
  logic [LEN_W-1:0] cnt;

  logic [OFF_W-1:0] w;
  logic [LEN_W-1:0] labs;
  logic [LEN_W-1:0] limit;
  logic             need_tok;
  logic             pad;
  logic [LEN_W-1:0] n;
  logic [LEN_W-1:0] k_inc;
  logic [LEN_W-1:0] len_now;
  logic             eq;
  logic [LIW-1:0]   la_idx;
  logic [7:0]       la_byte;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;
  logic             pop;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [OFF_W-1:0] wf_inc;

  always_comb begin
    w        = (wf < s_eff) ? wf : s_eff;
    labs     = (lf < l_eff) ? lf : l_eff;
    if (eotm) begin
      limit = (lf > labs) ? labs - LEN_W'(1) : labs;
    end else begin
      limit = l_eff - LEN_W'(1);
    end
    need_tok = eotm ? (lf != '0) : (lf >= l_eff);
    pad      = (best_len == labs);
    n        = pad ? labs : best_len + LEN_W'(1);
    k_inc    = k + LEN_W'(1);
    la_idx   = (state == S_FIN) ? best_len[LIW-1:0] : k[LIW-1:0];
    la_byte  = la[la_idx];
    eq       = (rdata == la_byte);
    len_now  = eq ? k_inc : k;
    raddr    = wp - AW'(off) + AW'(k);
    wf_inc   = (wf >= s_eff) ? s_eff : wf + OFF_W'(1);
  end

  assign item_ready = (state == S_IDLE) && !active;
  assign pop        = item_ready && item_valid;
  assign we         = pop && (lf < LEN_W'(LOOK_MAX));
  assign waddr      = wp + AW'(lf);

  lz77te_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (item.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      la[lf[LIW-1:0]] <= item.data;
    end else if (state == S_CONS) begin
      for (int i = 0; i < LOOK_MAX - 1; i++) begin
        la[i] <= la[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      lf        <= '0;
      wf        <= '0;
      eotm      <= 1'b0;
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (active && need_tok) begin
            best_len <= '0;
            best_off <= '0;
            off      <= OFF_W'(1);
            k        <= '0;
            state    <= (limit == '0 || w == '0) ? S_FIN : S_RD;
          end else if (active) begin
            active <= 1'b0;
          end else if (item_valid) begin
            if (lf < LEN_W'(LOOK_MAX)) begin
              lf <= lf + LEN_W'(1);
            end
            eotm   <= item.eot;
            active <= 1'b1;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (eq && k_inc < limit) begin
            k     <= k_inc;
            state <= S_RD;
          end else begin
            if (len_now > best_len) begin
              best_len <= len_now;
              best_off <= off;
            end
            if (off == w) begin
              state <= S_FIN;
            end else begin
              off   <= off + OFF_W'(1);
              k     <= '0;
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            match_offset <= best_off;
            match_length <= best_len;
            next_char    <= pad ? lz77te_pkg::PAD_CHAR : la_byte;
            char_is_pad  <= pad;
            last_token   <= eotm && (lf == n);
            cnt          <= n;
            state        <= S_CONS;
          end else begin
            out_valid <= 1'b1;
          end
        end
        S_CONS: begin
          wp  <= wp + AW'(1);
          wf  <= (cnt == LEN_W'(1) && eotm && lf == LEN_W'(1)) ? '0 : wf_inc;
          lf  <= lf - LEN_W'(1);
          cnt <= cnt - LEN_W'(1);
          if (cnt == LEN_W'(1)) begin
            state <= S_IDLE;
            if (eotm && lf == LEN_W'(1)) begin
              eotm   <= 1'b0;
              active <= 1'b0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/lz77_triple_encoder.sv
// LZ77 triple encoder.
// Input channel (in_valid/in_ready) takes one word per byte: data_byte and
// end_of_text. Output channel (out_valid/out_ready) gives one word per token:
// match_offset, match_length, next_char, char_is_pad, last_token.
// Config: cfg_we writes cfg_data to register cfg_index (0 search_size,
// 1 look_size); write only while the block is idle.
// A 2-word input queue decouples the input from the match engine.
// Each token takes a setup step, a RAM read (S_RD) and a compare (S_CMP)
// per compared byte over the window (RAM with one registered read port),
// a load of the output register (S_FIN), then a shift per consumed byte
// (S_CONS). A byte that causes no token is only stored. Input keeps
// entering the queue while a token is searched or waits at the output.
// Reset clears window and lookahead fill, search_size to SEARCH_MAX,
// look_size to LOOK_MAX; no memory clearing is needed.
// When the receiver stalls, the token holds in the output register and the
// engine waits in S_FIN with its next token; input stalls once the queue is full.
module lz77_triple_encoder #(
  parameter int SEARCH_MAX = 256,
  parameter int LOOK_MAX   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] data_byte,
  input  logic end_of_text,
  output logic out_valid,
  input  logic out_ready,
  output logic [$clog2(SEARCH_MAX+1)-1:0] match_offset,
  output logic [$clog2(LOOK_MAX+1)-1:0]   match_length,
  output logic [7:0] next_char,
  output logic char_is_pad,
  output logic last_token,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [(($clog2(SEARCH_MAX+1) > $clog2(LOOK_MAX+1)) ?
                 $clog2(SEARCH_MAX+1) : $clog2(LOOK_MAX+1))-1:0] cfg_data
);

  localparam int OFF_W = $clog2(SEARCH_MAX + 1);
  localparam int LEN_W = $clog2(LOOK_MAX + 1);

  logic [OFF_W-1:0] search_size;
  logic [LEN_W-1:0] look_size;
  logic [OFF_W-1:0] s_eff;
  logic [LEN_W-1:0] l_eff;
  logic              item_valid;
  logic              item_ready;
  lz77te_pkg::item_t item;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_size <= OFF_W'(SEARCH_MAX);
      look_size   <= LEN_W'(LOOK_MAX);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lz77te_pkg::REG_SEARCH_SIZE: search_size <= cfg_data[OFF_W-1:0];
        lz77te_pkg::REG_LOOK_SIZE:   look_size   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (search_size == '0) begin
      s_eff = OFF_W'(1);
    end else if (search_size > OFF_W'(SEARCH_MAX)) begin
      s_eff = OFF_W'(SEARCH_MAX);
    end else begin
      s_eff = search_size;
    end
    if (look_size == '0) begin
      l_eff = LEN_W'(1);
    end else if (look_size > LEN_W'(LOOK_MAX)) begin
      l_eff = LEN_W'(LOOK_MAX);
    end else begin
      l_eff = look_size;
    end
  end

  lz77te_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item)
  );

  lz77te_back #(.SEARCH_MAX(SEARCH_MAX), .LOOK_MAX(LOOK_MAX)) u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .s_eff        (s_eff),
    .l_eff        (l_eff),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_offset (match_offset),
    .match_length (match_length),
    .next_char    (next_char),
    .char_is_pad  (char_is_pad),
    .last_token   (last_token)
  );

  a_pad_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_is_pad |-> next_char == lz77te_pkg::PAD_CHAR)
    else $error("pad token without blank char");

  a_pad_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_is_pad |-> last_token)
    else $error("pad token before stream end");

  a_literal: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_offset == '0 |-> match_length == '0)
    else $error("match length without offset");

endmodule
